FILE: rtl/tlfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlfc_pkg
// Shared types and constants for the turn-light failsafe controller.
// ----------------------------------------------------------------------------
package tlfc_pkg;

	localparam int COLOR_W    = 24;
	localparam int TIME_W     = 64;
	localparam int TIMEOUT_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		CMD_START    = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_SNAPSHOT = 2'd2,
		CMD_LIGHT    = 2'd3
	} cmd_kind_t;

	typedef enum logic [2:0] {
		TURN_OFF     = 3'd0,
		TURN_LEFT    = 3'd1,
		TURN_RIGHT   = 3'd2,
		TURN_HAZARD  = 3'd3,
		TURN_UNKNOWN = 3'd4
	} turn_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_LEFT    = 2'd1,
		CFG_RIGHT   = 2'd2,
		CFG_HAZARD  = 2'd3
	} cfg_reg_t;

	localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 32'd500000;
	localparam logic [COLOR_W-1:0]   RST_LEFT    = 24'd65280;
	localparam logic [COLOR_W-1:0]   RST_RIGHT   = 24'd255;
	localparam logic [COLOR_W-1:0]   RST_HAZARD  = 24'd16760576;

	typedef struct packed {
		logic [1:0]         command;
		logic [TIME_W-1:0]  now_us;
		logic [2:0]         turn;
		logic               turn_valid;
		logic               health_online;
		logic [TIME_W-1:0]  turn_update_us;
		logic [COLOR_W-1:0] cmd_color;
		logic [TIME_W-1:0]  cmd_valid_until_us;
		logic               cmd_actionable;
		logic               sink_ok_first;
		logic               sink_ok_black;
	} in_item_t;

	typedef struct packed {
		logic               wrote_first;
		logic [COLOR_W-1:0] write_color;
		logic               wrote_fallback;
		logic               success;
		logic               fault;
	} out_item_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] fail_off_timeout_us;
		logic [COLOR_W-1:0]   left_color;
		logic [COLOR_W-1:0]   right_color;
		logic [COLOR_W-1:0]   hazard_color;
	} cfg_t;

endpackage
`default_nettype wire

FILE: rtl/tlfc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlfc_cfg
// Configuration register file: timeout and the three turn colors.
// ----------------------------------------------------------------------------
module tlfc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          we,
	input  wire logic [tlfc_pkg::CFG_IDX_W-1:0]  index,
	input  wire logic [tlfc_pkg::CFG_DATA_W-1:0] data,
	output tlfc_pkg::cfg_t                     cfg
);
	import tlfc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_off_timeout_us <= RST_TIMEOUT;
			cfg_q.left_color          <= RST_LEFT;
			cfg_q.right_color         <= RST_RIGHT;
			cfg_q.hazard_color        <= RST_HAZARD;
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				CFG_TIMEOUT: cfg_q.fail_off_timeout_us <= data[TIMEOUT_W-1:0];
				CFG_LEFT:    cfg_q.left_color          <= data[COLOR_W-1:0];
				CFG_RIGHT:   cfg_q.right_color         <= data[COLOR_W-1:0];
				CFG_HAZARD:  cfg_q.hazard_color        <= data[COLOR_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/tlfc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlfc_core
// Event decision logic and controller state: held command, fault latch and
// the color believed to be shown. State commits when the event moves on.
// ----------------------------------------------------------------------------
module tlfc_core #(
	parameter int COLOR_BITS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  tlfc_pkg::in_item_t item,
	input  tlfc_pkg::cfg_t     cfg,
	input  wire logic         update,
	output tlfc_pkg::out_item_t result
);
	import tlfc_pkg::*;

	localparam int HELD_W = (COLOR_BITS < COLOR_W) ? COLOR_BITS : COLOR_W;

	logic [HELD_W-1:0] held_color_q, held_color_d;
	logic [TIME_W-1:0] held_expiry_q, held_expiry_d;
	logic              held_act_q, held_act_d;
	logic              has_held_q, has_held_d;
	logic              fault_q, fault_d;
	logic [HELD_W-1:0] shown_color_q, shown_color_d;
	logic              shown_known_q, shown_known_d;

	logic [TIME_W:0]   exp_sum;
	logic [TIME_W-1:0] snap_expiry;
	logic [HELD_W-1:0] snap_color;
	logic              sig_ok;
	logic              fault_mid;
	logic              known_mid;
	logic [HELD_W-1:0] desired;
	logic              skip;

	always_comb begin
		// saturating expiry for snapshots
		exp_sum     = {1'b0, item.turn_update_us} + (TIME_W+1)'(cfg.fail_off_timeout_us);
		snap_expiry = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

		sig_ok     = item.health_online && item.turn_valid;
		snap_color = '0;
		if (sig_ok) begin
			priority if (item.turn == TURN_LEFT)   snap_color = cfg.left_color[HELD_W-1:0];
			else if (item.turn == TURN_RIGHT)      snap_color = cfg.right_color[HELD_W-1:0];
			else if (item.turn == TURN_HAZARD)     snap_color = cfg.hazard_color[HELD_W-1:0];
			else                                   snap_color = '0;
		end

		held_color_d  = held_color_q;
		held_expiry_d = held_expiry_q;
		held_act_d    = held_act_q;
		has_held_d    = has_held_q;
		fault_mid     = fault_q;
		known_mid     = shown_known_q;

		unique case (cmd_kind_t'(item.command))
			CMD_START: begin
				has_held_d = 1'b0;
				known_mid  = 1'b0;
				fault_mid  = 1'b0;
			end
			CMD_TICK: begin
			end
			CMD_SNAPSHOT: begin
				held_color_d  = snap_color;
				held_act_d    = snap_color != '0;
				held_expiry_d = snap_expiry;
				has_held_d    = 1'b1;
				fault_mid     = fault_q && !(shown_known_q && shown_color_q == '0);
			end
			CMD_LIGHT: begin
				held_color_d  = item.cmd_color[HELD_W-1:0];
				held_act_d    = item.cmd_actionable;
				held_expiry_d = item.cmd_valid_until_us;
				has_held_d    = 1'b1;
				fault_mid     = fault_q && !(shown_known_q && shown_color_q == '0);
			end
		endcase

		if (!fault_mid && has_held_d && held_act_d && item.now_us <= held_expiry_d)
			desired = held_color_d;
		else
			desired = '0;

		skip          = known_mid && desired == shown_color_q;
		fault_d       = fault_mid;
		shown_color_d = shown_color_q;
		shown_known_d = known_mid;

		result.write_color    = COLOR_W'(desired);
		result.wrote_first    = 1'b0;
		result.wrote_fallback = 1'b0;
		result.success        = 1'b1;

		if (!skip) begin
			result.wrote_first = 1'b1;
			if (item.sink_ok_first) begin
				shown_color_d = desired;
				shown_known_d = 1'b1;
			end else begin
				// failed write: latch fault, try black once unless black was the target
				result.success = 1'b0;
				fault_d        = 1'b1;
				shown_known_d  = 1'b0;
				if (desired != '0) begin
					result.wrote_fallback = 1'b1;
					if (item.sink_ok_black) begin
						shown_color_d = '0;
						shown_known_d = 1'b1;
					end
				end
			end
		end
		result.fault = fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_color_q  <= '0;
			held_expiry_q <= '0;
			held_act_q    <= 1'b0;
			has_held_q    <= 1'b0;
			fault_q       <= 1'b0;
			shown_color_q <= '0;
			shown_known_q <= 1'b0;
		end else if (update) begin
			held_color_q  <= held_color_d;
			held_expiry_q <= held_expiry_d;
			held_act_q    <= held_act_d;
			has_held_q    <= has_held_d;
			fault_q       <= fault_d;
			shown_color_q <= shown_color_d;
			shown_known_q <= shown_known_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/turn_light_failsafe_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// turn_light_failsafe_controller
// One RGB light driven from turn-signal events with expiry and fault fallback.
// ----------------------------------------------------------------------------
// Pipeline: input register, then the decision logic into the result register.
// Throughput: one transaction per cycle unless out_ready holds back the
//   result register; the input register refills in the same cycle the
//   result register is loaded.
// Reset: arst_n clears control state, the held command and the fault latch;
//   configuration returns to its defaults. No clearing pass.
module turn_light_failsafe_controller #(
	parameter int COLOR_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  tlfc_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output tlfc_pkg::out_item_t                  out_data,
	input  wire logic                            cfg_we,
	input  wire logic [tlfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tlfc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tlfc_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_s2;
	logic      valid_s2;
	logic      adv;
	cfg_t      cfg;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	tlfc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tlfc_core #(
		.COLOR_BITS (COLOR_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.cfg    (cfg),
		.update (adv),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (adv)
			out_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

endmodule
`default_nettype wire
